### hw/rtl/twao_pkg.sv
// Shared types, constants and helper functions for the three-wheel arc odometry core.
// Depends on nothing; the divider, the CORDIC and the top level import it.
package twao_pkg;

    localparam int unsigned STEP_W   = 5;
    localparam int unsigned MAX_STEPS = 30;
    localparam int unsigned RED_TOP  = 23;

    localparam logic signed [32:0] ARC_K       = 33'sd585635;
    localparam logic signed [63:0] ARC_LIM     = 64'sh0000_0800_0000_0000;
    localparam logic signed [63:0] SAT_HEAD    = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic        [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [2:0] REG_RADIUS  = 3'd0;
    localparam logic [2:0] REG_LEFT    = 3'd1;
    localparam logic [2:0] REG_RIGHT   = 3'd2;
    localparam logic [2:0] REG_BACK    = 3'd3;
    localparam logic [2:0] REG_HEADING = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RED,
        CS_FIX,
        CS_ROT,
        CS_OUT
    } cordic_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ARC_MUL,
        S_ARC_CLAMP,
        S_ARC_LO,
        S_ARC_HI,
        S_ARC_SUM,
        S_TRAVEL,
        S_HEAD_DIV,
        S_HEAD_WAIT,
        S_HEAD_SET,
        S_DELTA,
        S_CHORD_GO,
        S_CHORD_WAIT,
        S_BX_MUL,
        S_BX_OFF,
        S_BX_TERM,
        S_BX_WAIT,
        S_RY_MUL,
        S_RY_OFF,
        S_RY_TERM,
        S_RY_WAIT,
        S_ROT_GO,
        S_ROT_WAIT,
        S_ROT_XA,
        S_ROT_XB,
        S_ROT_XS,
        S_ROT_YA,
        S_ROT_YS,
        S_OUT
    } seq_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/twao_mul.sv
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing.
module twao_mul
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [63:0] p
);
    logic signed [65:0] full;
    logic signed [63:0] p_reg;

    assign full = a * b;
    assign p    = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= full[63:0];
    end
endmodule

### hw/rtl/twao_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on twao_pkg.
module twao_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [63:0]     dividend,
    input  logic signed [63:0]     divisor,
    output logic signed [63:0]     quot,
    output twao_pkg::unit_status_t status
);
    import twao_pkg::*;

    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [63:0] d_reg;
    logic [63:0] n_reg;
    logic [63:0] rem_reg;
    logic [64:0] trial;
    logic        fits;

    assign trial = {rem_reg, n_reg[63]};
    assign fits  = trial >= {1'b0, d_reg};
    assign quot  = neg_reg ? -$signed(n_reg) : $signed(n_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 7'd64;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor[63] ? 64'(-divisor) : 64'(divisor);
            n_reg   <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            rem_reg <= '0;
            neg_reg <= dividend[63] ^ divisor[63];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 64'(trial - {1'b0, d_reg}) : trial[63:0];
            n_reg   <= {n_reg[62:0], fits};
        end
    end
endmodule

### hw/rtl/twao_cordic.sv
// Iterative rotation-mode CORDIC in Q2.30 with modulo-2pi angle reduction.
// Depends on twao_pkg.
module twao_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [63:0]     angle,
    output logic signed [31:0]     cos_q,
    output logic signed [31:0]     sin_q,
    output twao_pkg::unit_status_t status
);
    import twao_pkg::*;

    localparam int NSTEP = (STEPS < MAX_STEPS) ? STEPS : MAX_STEPS;

    cordic_state_t      st_reg;
    cordic_state_t      st_next;
    logic               done_reg;
    logic [STEP_W-1:0]  k_reg;
    logic [STEP_W-1:0]  i_reg;
    logic [63:0]        mag_reg;
    logic               sgn_reg;
    logic               flip_reg;
    logic signed [33:0] r_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic [63:0]        twopi_k;
    logic signed [63:0] r0;
    logic signed [63:0] r1;
    logic signed [63:0] r2;
    logic               flip;
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    assign cos_q       = cos_reg;
    assign sin_q       = sin_reg;
    assign status.busy = (st_reg != CS_IDLE);
    assign status.done = done_reg;
    assign twopi_k     = TWO_PI_Q30 << k_reg;
    assign xs          = x_reg >>> i_reg;
    assign ys          = y_reg >>> i_reg;

    always_comb
    begin
        r0 = sgn_reg ? -$signed(mag_reg) : $signed(mag_reg);
        r1 = r0;
        if (r0 > PI_Q30)
            r1 = r0 - $signed(TWO_PI_Q30);
        else if (r0 < -PI_Q30)
            r1 = r0 + $signed(TWO_PI_Q30);
        r2   = r1;
        flip = 1'b0;
        if (r1 > HALF_PI_Q30)
        begin
            r2   = r1 - PI_Q30;
            flip = 1'b1;
        end
        else if (r1 < -HALF_PI_Q30)
        begin
            r2   = r1 + PI_Q30;
            flip = 1'b1;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            CS_IDLE: if (start) st_next = CS_RED;
            CS_RED:  if (k_reg == '0) st_next = CS_FIX;
            CS_FIX:  st_next = CS_ROT;
            CS_ROT:  if (i_reg == STEP_W'(NSTEP - 1)) st_next = CS_OUT;
            CS_OUT:  st_next = CS_IDLE;
            default: st_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= CS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == CS_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    sgn_reg <= angle[63];
                    mag_reg <= angle[63] ? 64'(-angle) : 64'(angle);
                    k_reg   <= STEP_W'(RED_TOP);
                end
            end
            CS_RED:
            begin
                if (mag_reg >= twopi_k)
                    mag_reg <= mag_reg - twopi_k;
                k_reg <= k_reg - 1'b1;
            end
            CS_FIX:
            begin
                r_reg    <= r2[33:0];
                flip_reg <= flip;
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                i_reg    <= '0;
            end
            CS_ROT:
            begin
                if (r_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    r_reg <= r_reg - atan_q30(i_reg);
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    r_reg <= r_reg + atan_q30(i_reg);
                end
                i_reg <= i_reg + 1'b1;
            end
            CS_OUT:
            begin
                cos_reg <= flip_reg ? 32'(-x_reg) : x_reg[31:0];
                sin_reg <= flip_reg ? 32'(-y_reg) : y_reg[31:0];
            end
            default:
            begin
            end
        endcase
    end
endmodule

### hw/rtl/three_wheel_arc_odometry_core.sv
// Three-wheel arc odometry top level: sequencer, state and configuration registers.
// Depends on twao_pkg, twao_mul, twao_div and twao_cordic.
//
// Usage: each s_tdata item carries left, right and back wheel angles (1/64 degree).
// One m_tdata item comes back per input item with x, y and heading in Q16.16.
// Configuration (wheel radius, wheel offsets, start heading) is written through
// cfg_wr_en / cfg_index / cfg_data while the core is idle; unknown indexes are ignored.
// A zero wheel spacing skips the heading division. The time is set by the divider
// waits (one for the heading, two for the chord terms) and the CORDIC waits (one for
// the chord, one for the rotation); when the heading does not change, the chord CORDIC
// and both chord-term divisions are skipped. The arc lengths take three multiplier
// passes per wheel on the shared multiplier.
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next item is taken while m_tvalid waits on m_tready.
// If a result is still unclaimed when the next one is done, the sequencer holds.
// Reset clears position, heading, travel sums and last angles to zero and loads
// the default configuration.
module three_wheel_arc_odometry_core
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // left_angle, right_angle, back_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x, pos_y, heading
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import twao_pkg::*;

    localparam int UP_SH = 29 - FRAC_BITS;

    seq_state_t         st_reg;
    seq_state_t         st_next;
    logic [1:0]         w_reg;
    logic [23:0]        radius_reg;
    logic [23:0]        loff_reg;
    logic [23:0]        roff_reg;
    logic [23:0]        boff_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] ang_reg [3];
    logic signed [31:0] last_reg [3];
    logic signed [31:0] arc_reg [3];
    logic signed [31:0] lts_reg;
    logic signed [31:0] rts_reg;
    logic signed [31:0] hd_reg;
    logic signed [31:0] xn_reg;
    logic signed [31:0] yn_reg;
    logic signed [31:0] newh_reg;
    logic signed [32:0] dh_reg;
    logic signed [44:0] p_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] q_reg;
    logic signed [63:0] t_reg;
    logic signed [31:0] chord_reg;
    logic signed [31:0] lx_reg;
    logic signed [31:0] ly_reg;
    logic signed [31:0] ca_reg;
    logic signed [31:0] sa_reg;
    logic               mv_reg;
    logic [95:0]        mdata_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [63:0] mul_q;
    logic               div_start;
    logic signed [63:0] div_n;
    logic signed [63:0] div_d;
    logic signed [63:0] div_q;
    unit_status_t       div_st;
    logic               cor_start;
    logic signed [63:0] cor_ang;
    logic signed [31:0] cor_cos;
    logic signed [31:0] cor_sin;
    unit_status_t       cor_st;

    logic signed [63:0] diff;
    logic [24:0]        spacing;
    logic signed [32:0] dh_now;
    logic signed [63:0] arc_sum;
    logic               load_out;

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign spacing  = {1'b0, loff_reg} + {1'b0, roff_reg};
    assign diff     = 64'(lts_reg) - 64'(rts_reg);
    assign dh_now   = 33'(newh_reg) - 33'(hd_reg);
    assign arc_sum  = acc_reg + (mul_q <<< 24);
    assign load_out = (st_reg == S_OUT) && (!mv_reg || m_tready);

    twao_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_q)
    );

    twao_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quot     (div_q),
        .status   (div_st)
    );

    twao_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_ang),
        .cos_q  (cor_cos),
        .sin_q  (cor_sin),
        .status (cor_st)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:       if (s_tvalid) st_next = S_ARC_MUL;
            S_ARC_MUL:    st_next = S_ARC_CLAMP;
            S_ARC_CLAMP:  st_next = S_ARC_LO;
            S_ARC_LO:     st_next = S_ARC_HI;
            S_ARC_HI:     st_next = S_ARC_SUM;
            S_ARC_SUM:    st_next = (w_reg == 2'd2) ? S_TRAVEL : S_ARC_MUL;
            S_TRAVEL:     st_next = S_HEAD_DIV;
            S_HEAD_DIV:   st_next = (spacing == '0) ? S_HEAD_SET : S_HEAD_WAIT;
            S_HEAD_WAIT:  if (div_st.done) st_next = S_HEAD_SET;
            S_HEAD_SET:   st_next = S_DELTA;
            S_DELTA:      st_next = (dh_now == '0) ? S_ROT_GO : S_CHORD_GO;
            S_CHORD_GO:   st_next = S_CHORD_WAIT;
            S_CHORD_WAIT: if (cor_st.done) st_next = S_BX_MUL;
            S_BX_MUL:     st_next = S_BX_OFF;
            S_BX_OFF:     st_next = S_BX_TERM;
            S_BX_TERM:    st_next = S_BX_WAIT;
            S_BX_WAIT:    if (div_st.done) st_next = S_RY_MUL;
            S_RY_MUL:     st_next = S_RY_OFF;
            S_RY_OFF:     st_next = S_RY_TERM;
            S_RY_TERM:    st_next = S_RY_WAIT;
            S_RY_WAIT:    if (div_st.done) st_next = S_ROT_GO;
            S_ROT_GO:     st_next = S_ROT_WAIT;
            S_ROT_WAIT:   if (cor_st.done) st_next = S_ROT_XA;
            S_ROT_XA:     st_next = S_ROT_XB;
            S_ROT_XB:     st_next = S_ROT_XS;
            S_ROT_XS:     st_next = S_ROT_YA;
            S_ROT_YA:     st_next = S_ROT_YS;
            S_ROT_YS:     st_next = S_OUT;
            S_OUT:        if (!mv_reg || m_tready) st_next = S_IDLE;
            default:      st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        cor_start = 1'b0;
        cor_ang   = '0;
        case (st_reg)
            S_ARC_MUL:
            begin
                mul_a = 33'(ang_reg[w_reg]) - 33'(last_reg[w_reg]);
                mul_b = $signed({9'd0, radius_reg});
            end
            S_ARC_LO:
            begin
                mul_a = $signed({9'd0, p_reg[23:0]});
                mul_b = ARC_K;
            end
            S_ARC_HI:
            begin
                mul_a = 33'($signed(p_reg[44:24]));
                mul_b = ARC_K;
            end
            S_HEAD_DIV:
            begin
                div_start = (spacing != '0);
                div_n     = diff <<< FRAC_BITS;
                div_d     = $signed({39'd0, spacing});
            end
            S_CHORD_GO:
            begin
                cor_start = 1'b1;
                cor_ang   = 64'(dh_reg) <<< UP_SH;
            end
            S_BX_MUL:
            begin
                mul_a = 33'(chord_reg);
                mul_b = 33'(arc_reg[2]);
            end
            S_BX_OFF:
            begin
                div_start = 1'b1;
                div_n     = mul_q;
                div_d     = 64'(dh_reg);
                mul_a     = 33'(chord_reg);
                mul_b     = $signed({9'd0, boff_reg});
            end
            S_RY_MUL:
            begin
                mul_a = 33'(chord_reg);
                mul_b = 33'(arc_reg[1]);
            end
            S_RY_OFF:
            begin
                div_start = 1'b1;
                div_n     = mul_q;
                div_d     = 64'(dh_reg);
                mul_a     = 33'(chord_reg);
                mul_b     = $signed({9'd0, roff_reg});
            end
            S_ROT_GO:
            begin
                cor_start = 1'b1;
                cor_ang   = (64'(hd_reg) + 64'(newh_reg)) <<< UP_SH;
            end
            S_ROT_XA:
            begin
                mul_a = 33'(lx_reg);
                mul_b = 33'(ca_reg);
            end
            S_ROT_XB:
            begin
                mul_a = 33'(ly_reg);
                mul_b = 33'(sa_reg);
            end
            S_ROT_XS:
            begin
                mul_a = 33'(ly_reg);
                mul_b = 33'(ca_reg);
            end
            S_ROT_YA:
            begin
                mul_a = 33'(lx_reg);
                mul_b = 33'(sa_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            mv_reg     <= 1'b0;
            w_reg      <= '0;
            radius_reg <= 24'd90112;
            loff_reg   <= 24'd327680;
            roff_reg   <= 24'd327680;
            boff_reg   <= 24'd327680;
            start_reg  <= '0;
            last_reg   <= '{default: '0};
            lts_reg    <= '0;
            rts_reg    <= '0;
            hd_reg     <= '0;
            xn_reg     <= '0;
            yn_reg     <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (load_out)
                mv_reg <= 1'b1;
            else if (m_tready)
                mv_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RADIUS:  radius_reg <= cfg_data[23:0];
                    REG_LEFT:    loff_reg   <= cfg_data[23:0];
                    REG_RIGHT:   roff_reg   <= cfg_data[23:0];
                    REG_BACK:    boff_reg   <= cfg_data[23:0];
                    REG_HEADING: start_reg  <= $signed(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
            case (st_reg)
                S_IDLE:
                    w_reg <= '0;
                S_ARC_SUM:
                begin
                    last_reg[w_reg] <= ang_reg[w_reg];
                    w_reg           <= w_reg + 2'd1;
                end
                S_TRAVEL:
                begin
                    lts_reg <= sat32(64'(lts_reg) + 64'(arc_reg[0]));
                    rts_reg <= sat32(64'(rts_reg) + 64'(arc_reg[1]));
                end
                S_ROT_XS:
                    xn_reg <= sat32(64'(xn_reg)
                        + ((acc_reg + mul_q + 64'sd536870912) >>> 30));
                S_ROT_YS:
                begin
                    yn_reg <= sat32(64'(yn_reg)
                        + ((acc_reg - mul_q + 64'sd536870912) >>> 30));
                    hd_reg <= newh_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            mdata_reg <= {hd_reg, yn_reg, xn_reg};
        case (st_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ang_reg[0] <= $signed(s_tdata[31:0]);
                    ang_reg[1] <= $signed(s_tdata[63:32]);
                    ang_reg[2] <= $signed(s_tdata[95:64]);
                end
            end
            S_ARC_CLAMP:
            begin
                if (mul_q > ARC_LIM)
                    p_reg <= ARC_LIM[44:0];
                else if (mul_q < -ARC_LIM)
                    p_reg <= 45'(-ARC_LIM);
                else
                    p_reg <= mul_q[44:0];
            end
            S_ARC_HI:
                acc_reg <= mul_q;
            S_ARC_SUM:
                arc_reg[w_reg] <= sat32((arc_sum + 64'sd1073741824) >>> 31);
            S_HEAD_DIV:
            begin
                if (diff > 0)
                    q_reg <= SAT_HEAD;
                else if (diff < 0)
                    q_reg <= -SAT_HEAD;
                else
                    q_reg <= '0;
            end
            S_HEAD_WAIT:
                if (div_st.done) q_reg <= div_q;
            S_HEAD_SET:
                newh_reg <= sat32(64'(start_reg) + q_reg);
            S_DELTA:
            begin
                dh_reg <= dh_now;
                lx_reg <= arc_reg[2];
                ly_reg <= arc_reg[1];
            end
            S_CHORD_WAIT:
                if (cor_st.done)
                    chord_reg <= (cor_sin + (32'sd1 <<< (UP_SH - 1))) >>> UP_SH;
            S_BX_TERM, S_RY_TERM:
                t_reg <= (mul_q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            S_BX_WAIT:
                if (div_st.done) lx_reg <= sat32(div_q + t_reg);
            S_RY_WAIT:
                if (div_st.done) ly_reg <= sat32(div_q + t_reg);
            S_ROT_WAIT:
            begin
                if (cor_st.done)
                begin
                    ca_reg <= cor_cos;
                    sa_reg <= cor_sin;
                end
            end
            S_ROT_XB, S_ROT_YA:
                acc_reg <= mul_q;
            default:
            begin
            end
        endcase
    end
endmodule
